[rtl/fsps_pkg.sv]
// fsps_pkg: shared types, constants and helpers of the scheduler tick unit
// used by five_state_process_scheduler_tick_unit; depends on nothing
`default_nettype none

package fsps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int TIME_W    = 16;
  localparam int ID_W      = 5;
  localparam int IDX_W     = 4;
  localparam int LEN_W     = 5;
  localparam int PRIO_W    = 8;
  localparam int BURST_W   = 8;
  localparam int MODE_W    = 2;
  localparam int CFG_AW    = 1;

  localparam logic [LEN_W-1:0] LIST_FULL = LEN_W'(MAX_PROCS);

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RR   = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_AW-1:0] REG_MODE    = 1'b0;
  localparam logic [CFG_AW-1:0] REG_QUANTUM = 1'b1;

  localparam logic [TIME_W-1:0] QUANTUM_RST = TIME_W'(4);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tm;
  } slot_t;

  typedef slot_t [MAX_PROCS-1:0] list_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] bursts;
    logic [TIME_W-1:0]  burst_len;
    logic [TIME_W-1:0]  block_len;
  } entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] rdy;
    logic [TIME_W-1:0] run;
    logic [TIME_W-1:0] blk;
  } totals_t;

  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
    return (v != '1) ? v + TIME_W'(1) : v;
  endfunction

  function automatic logic [TIME_W-1:0] sat_dec(input logic [TIME_W-1:0] v);
    return (v != '0) ? v - TIME_W'(1) : v;
  endfunction

  function automatic logic [IDX_W-1:0] idx_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] t;
    t = id - ID_W'(1);
    return t[IDX_W-1:0];
  endfunction

  // drop entry k and close the gap
  function automatic list_t list_remove(input list_t l, input logic [IDX_W-1:0] k);
    list_t r;
    r = l;
    for (int i = 0; i < MAX_PROCS - 1; i++) begin
      if (IDX_W'(i) >= k) r[i] = l[i+1];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/five_state_process_scheduler_tick_unit.sv]
// scheduler tick unit: a load is written straight from idle; a tick walks the blocked list,
// the new list, the running process and the ready queue through the process table and
// totals memories, each entry read and then written; in priority mode the ready queue is
// also scanned at dispatch; one item at a time, the next item is accepted once the result
// is in the output register
// reset (async, active low) empties all lists, clears the cpu and the counters, quantum = 4
// table and totals memories are not cleared; each entry is written by its load
`default_nettype none

module five_state_process_scheduler_tick_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fsps_pkg::CFG_AW-1:0] cfg_addr_i,
  input  wire logic [fsps_pkg::TIME_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        op_i,
  input  wire logic [fsps_pkg::ID_W-1:0]   proc_id_i,
  input  wire logic [fsps_pkg::PRIO_W-1:0] prio_level_i,
  input  wire logic [fsps_pkg::BURST_W-1:0] burst_count_i,
  input  wire logic [fsps_pkg::TIME_W-1:0] burst_len_i,
  input  wire logic [fsps_pkg::TIME_W-1:0] block_len_i,
  input  wire logic [fsps_pkg::TIME_W-1:0] arrival_delay_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [fsps_pkg::TIME_W-1:0]      tick_index_o,
  output logic                             running_valid_o,
  output logic [fsps_pkg::ID_W-1:0]        running_id_o,
  output logic [fsps_pkg::LEN_W-1:0]       ready_count_o,
  output logic                             exit_valid_o,
  output logic [fsps_pkg::ID_W-1:0]        exit_id_o,
  output logic [fsps_pkg::TIME_W-1:0]      departure_tick_o,
  output logic [fsps_pkg::TIME_W-1:0]      ready_total_o,
  output logic [fsps_pkg::TIME_W-1:0]      run_total_o,
  output logic [fsps_pkg::TIME_W-1:0]      blocked_total_o,
  output logic [fsps_pkg::TIME_W-1:0]      turnaround_o
);
  import fsps_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_BLK_RD  = 4'd1;
  localparam logic [3:0] S_BLK_WR  = 4'd2;
  localparam logic [3:0] S_NEW_RD  = 4'd3;
  localparam logic [3:0] S_NEW_WR  = 4'd4;
  localparam logic [3:0] S_RUN_RD  = 4'd5;
  localparam logic [3:0] S_RUN_WR  = 4'd6;
  localparam logic [3:0] S_DSP     = 4'd7;
  localparam logic [3:0] S_PRI_RD  = 4'd8;
  localparam logic [3:0] S_PRI_CMP = 4'd9;
  localparam logic [3:0] S_PRI_SEL = 4'd10;
  localparam logic [3:0] S_RDY_RD  = 4'd11;
  localparam logic [3:0] S_RDY_WR  = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  logic [3:0]         state_q, state_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [TIME_W-1:0]  quantum_q, quantum_d;
  list_t              new_q, new_d, blk_q, blk_d, rdy_q, rdy_d;
  logic [LEN_W-1:0]   nlen_q, nlen_d, blen_q, blen_d, rlen_q, rlen_d;
  logic [ID_W-1:0]    holder_q, holder_d;
  logic [TIME_W-1:0]  burst_q, burst_d;
  logic [TIME_W-1:0]  qleft_q, qleft_d;
  logic [TIME_W-1:0]  tick_q, tick_d;
  logic [LEN_W-1:0]   k_q, k_d, keep_q, keep_d;
  logic [ID_W-1:0]    exit_q, exit_d;
  logic [IDX_W-1:0]   best_q, best_d;
  logic [PRIO_W-1:0]  best_prio_q, best_prio_d;
  logic [TIME_W-1:0]  best_blen_q, best_blen_d;

  logic               out_valid_q, out_valid_d;
  logic [TIME_W-1:0]  o_tick_q, o_tick_d, o_rdy_q, o_rdy_d, o_run_q, o_run_d;
  logic [TIME_W-1:0]  o_blk_q, o_blk_d, o_turn_q, o_turn_d;
  logic [ID_W-1:0]    o_run_id_q, o_run_id_d, o_exit_q, o_exit_d;
  logic [LEN_W-1:0]   o_rcnt_q, o_rcnt_d;

  // process table and totals, one shared address port
  entry_t             tbl_mem [MAX_PROCS];
  totals_t            tot_mem [MAX_PROCS];
  entry_t             tbl_rd_q, tbl_wdata;
  totals_t            tot_rd_q, tot_wdata;
  logic [IDX_W-1:0]   mem_addr;
  logic               mem_re, tbl_we, tot_we;

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[mem_addr] <= tbl_wdata;
    if (tot_we) tot_mem[mem_addr] <= tot_wdata;
    if (mem_re) begin
      tbl_rd_q <= tbl_mem[mem_addr];
      tot_rd_q <= tot_mem[mem_addr];
    end
  end

  logic rr, by_prio;
  assign rr      = (mode_q == MODE_RR);
  assign by_prio = (mode_q == MODE_PRIO);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    slot_t             s, old;
    logic [TIME_W-1:0] t;
    logic [BURST_W-1:0] bl;
    logic [LEN_W-1:0]  last;
    logic [TIME_W+1:0] sum;
    entry_t            e;

    state_d = state_q;  mode_d = mode_q;  quantum_d = quantum_q;
    new_d = new_q;  blk_d = blk_q;  rdy_d = rdy_q;
    nlen_d = nlen_q;  blen_d = blen_q;  rlen_d = rlen_q;
    holder_d = holder_q;  burst_d = burst_q;  qleft_d = qleft_q;  tick_d = tick_q;
    k_d = k_q;  keep_d = keep_q;  exit_d = exit_q;
    best_d = best_q;  best_prio_d = best_prio_q;  best_blen_d = best_blen_q;
    out_valid_d = out_valid_q;
    o_tick_d = o_tick_q;  o_rdy_d = o_rdy_q;  o_run_d = o_run_q;  o_blk_d = o_blk_q;
    o_turn_d = o_turn_q;  o_run_id_d = o_run_id_q;  o_exit_d = o_exit_q;
    o_rcnt_d = o_rcnt_q;
    mem_addr = '0;  mem_re = 1'b0;  tbl_we = 1'b0;  tot_we = 1'b0;
    tbl_wdata = tbl_rd_q;  tot_wdata = tot_rd_q;
    s = '0;  old = '0;  t = '0;  bl = '0;  last = '0;  sum = '0;  e = '0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_LOAD) begin
            if (proc_id_i != '0 && proc_id_i <= ID_W'(MAX_PROCS)) begin
              mem_addr  = idx_of(proc_id_i);
              tbl_we    = 1'b1;
              tot_we    = 1'b1;
              tbl_wdata = '{prio: prio_level_i, bursts: burst_count_i,
                            burst_len: burst_len_i, block_len: block_len_i};
              tot_wdata = '0;
              if (burst_count_i != '0 && nlen_q < LIST_FULL) begin
                new_d[nlen_q[IDX_W-1:0]] = '{id: proc_id_i, tm: arrival_delay_i};
                nlen_d = nlen_q + LEN_W'(1);
              end
            end
          end else begin
            // quantum check ahead of the tick
            if (rr && holder_q != '0 && qleft_q == '0) begin
              if (rlen_q != '0) begin
                old      = '{id: holder_q, tm: burst_q};
                holder_d = rdy_q[0].id;
                burst_d  = rdy_q[0].tm;
                rdy_d    = list_remove(rdy_q, '0);
                last     = rlen_q - LEN_W'(1);
                rdy_d[last[IDX_W-1:0]] = old;
              end
              qleft_d = quantum_q;
            end
            k_d = '0;  keep_d = '0;  exit_d = '0;
            state_d = S_BLK_RD;
          end
        end
      end
      S_BLK_RD: begin
        if (k_q < blen_q) begin
          mem_addr = idx_of(blk_q[k_q[IDX_W-1:0]].id);
          mem_re   = 1'b1;
          state_d  = S_BLK_WR;
        end else begin
          blen_d = keep_q;  k_d = '0;  keep_d = '0;
          state_d = S_NEW_RD;
        end
      end
      S_BLK_WR: begin
        s = blk_q[k_q[IDX_W-1:0]];
        mem_addr = idx_of(s.id);
        tot_we = 1'b1;
        tot_wdata.blk = sat_inc(tot_rd_q.blk);
        t = sat_dec(s.tm);
        if (t == '0) begin
          if (rlen_q < LIST_FULL) begin
            rdy_d[rlen_q[IDX_W-1:0]] = '{id: s.id, tm: tbl_rd_q.burst_len};
            rlen_d = rlen_q + LEN_W'(1);
          end
        end else begin
          blk_d[keep_q[IDX_W-1:0]] = '{id: s.id, tm: t};
          keep_d = keep_q + LEN_W'(1);
        end
        k_d = k_q + LEN_W'(1);
        state_d = S_BLK_RD;
      end
      S_NEW_RD: begin
        if (k_q < nlen_q) begin
          mem_addr = idx_of(new_q[k_q[IDX_W-1:0]].id);
          mem_re   = 1'b1;
          state_d  = S_NEW_WR;
        end else begin
          nlen_d = keep_q;
          state_d = S_RUN_RD;
        end
      end
      S_NEW_WR: begin
        s = new_q[k_q[IDX_W-1:0]];
        if (s.tm == '0) begin
          if (rlen_q < LIST_FULL) begin
            rdy_d[rlen_q[IDX_W-1:0]] = '{id: s.id, tm: tbl_rd_q.burst_len};
            rlen_d = rlen_q + LEN_W'(1);
          end
        end else begin
          new_d[keep_q[IDX_W-1:0]] = '{id: s.id, tm: s.tm - TIME_W'(1)};
          keep_d = keep_q + LEN_W'(1);
        end
        k_d = k_q + LEN_W'(1);
        state_d = S_NEW_RD;
      end
      S_RUN_RD: begin
        if (holder_q != '0) begin
          mem_addr = idx_of(holder_q);
          mem_re   = 1'b1;
          state_d  = S_RUN_WR;
        end else begin
          state_d = S_DSP;
        end
      end
      S_RUN_WR: begin
        mem_addr = idx_of(holder_q);
        tot_we = 1'b1;
        tot_wdata.run = sat_inc(tot_rd_q.run);
        t = sat_dec(burst_q);
        burst_d = t;
        if (t == '0) begin
          holder_d = '0;
          bl = (tbl_rd_q.bursts != '0) ? tbl_rd_q.bursts - BURST_W'(1) : '0;
          e = tbl_rd_q;
          e.bursts = bl;
          tbl_we = 1'b1;
          tbl_wdata = e;
          if (bl == '0) begin
            exit_d = holder_q;
          end else if (blen_q < LIST_FULL) begin
            blk_d[blen_q[IDX_W-1:0]] = '{id: holder_q, tm: tbl_rd_q.block_len};
            blen_d = blen_q + LEN_W'(1);
          end
          if (rr) qleft_d = quantum_q;
        end else if (rr) begin
          qleft_d = sat_dec(qleft_q);
        end
        state_d = S_DSP;
      end
      S_DSP: begin
        k_d = '0;
        state_d = S_RDY_RD;
        if (rr) begin
          if (holder_q == '0) begin
            if (rlen_q != '0) begin
              holder_d = rdy_q[0].id;
              burst_d  = rdy_q[0].tm;
              rdy_d    = list_remove(rdy_q, '0);
              rlen_d   = rlen_q - LEN_W'(1);
            end
            qleft_d = quantum_q;
          end else if (qleft_q == '0) begin
            if (rlen_q != '0) begin
              old      = '{id: holder_q, tm: burst_q};
              holder_d = rdy_q[0].id;
              burst_d  = rdy_q[0].tm;
              rdy_d    = list_remove(rdy_q, '0);
              last     = rlen_q - LEN_W'(1);
              rdy_d[last[IDX_W-1:0]] = old;
            end
            qleft_d = quantum_q;
          end
        end else if (holder_q == '0 && rlen_q != '0) begin
          state_d = S_PRI_RD;
        end
      end
      S_PRI_RD: begin
        mem_addr = idx_of(rdy_q[k_q[IDX_W-1:0]].id);
        mem_re   = 1'b1;
        state_d  = S_PRI_CMP;
      end
      S_PRI_CMP: begin
        // strict compare keeps the earliest entry on a tie
        if (k_q == '0 || (by_prio && tbl_rd_q.prio < best_prio_q)) begin
          best_d      = k_q[IDX_W-1:0];
          best_prio_d = tbl_rd_q.prio;
          best_blen_d = tbl_rd_q.burst_len;
        end
        k_d = k_q + LEN_W'(1);
        if (by_prio && (k_q + LEN_W'(1)) < rlen_q) state_d = S_PRI_RD;
        else state_d = S_PRI_SEL;
      end
      S_PRI_SEL: begin
        holder_d = rdy_q[best_q].id;
        burst_d  = best_blen_q;
        rdy_d    = list_remove(rdy_q, best_q);
        rlen_d   = rlen_q - LEN_W'(1);
        k_d      = '0;
        state_d  = S_RDY_RD;
      end
      S_RDY_RD: begin
        if (k_q < rlen_q) begin
          mem_addr = idx_of(rdy_q[k_q[IDX_W-1:0]].id);
          mem_re   = 1'b1;
          state_d  = S_RDY_WR;
        end else begin
          if (exit_q != '0) begin
            mem_addr = idx_of(exit_q);
            mem_re   = 1'b1;
          end
          state_d = S_OUT;
        end
      end
      S_RDY_WR: begin
        mem_addr = idx_of(rdy_q[k_q[IDX_W-1:0]].id);
        tot_we = 1'b1;
        tot_wdata.rdy = sat_inc(tot_rd_q.rdy);
        k_d = k_q + LEN_W'(1);
        state_d = S_RDY_RD;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          o_tick_d    = tick_q;
          o_run_id_d  = holder_q;
          o_rcnt_d    = rlen_q;
          o_exit_d    = exit_q;
          if (exit_q != '0) begin
            sum = {2'b00, tot_rd_q.rdy} + {2'b00, tot_rd_q.run} + {2'b00, tot_rd_q.blk};
            o_rdy_d  = tot_rd_q.rdy;
            o_run_d  = tot_rd_q.run;
            o_blk_d  = tot_rd_q.blk;
            o_turn_d = (sum[TIME_W+1:TIME_W] != '0) ? '1 : sum[TIME_W-1:0];
          end else begin
            o_rdy_d = '0;  o_run_d = '0;  o_blk_d = '0;  o_turn_d = '0;
          end
          tick_d  = sat_inc(tick_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_MODE:    mode_d = cfg_wdata_i[MODE_W-1:0];
        REG_QUANTUM: begin
          quantum_d = cfg_wdata_i;
          qleft_d   = cfg_wdata_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FCFS;
      quantum_q   <= QUANTUM_RST;
      qleft_q     <= QUANTUM_RST;
      nlen_q      <= '0;
      blen_q      <= '0;
      rlen_q      <= '0;
      holder_q    <= '0;
      burst_q     <= '0;
      tick_q      <= '0;
      k_q         <= '0;
      keep_q      <= '0;
      exit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      quantum_q   <= quantum_d;
      qleft_q     <= qleft_d;
      nlen_q      <= nlen_d;
      blen_q      <= blen_d;
      rlen_q      <= rlen_d;
      holder_q    <= holder_d;
      burst_q     <= burst_d;
      tick_q      <= tick_d;
      k_q         <= k_d;
      keep_q      <= keep_d;
      exit_q      <= exit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q       <= new_d;
    blk_q       <= blk_d;
    rdy_q       <= rdy_d;
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    best_blen_q <= best_blen_d;
    o_tick_q    <= o_tick_d;
    o_rdy_q     <= o_rdy_d;
    o_run_q     <= o_run_d;
    o_blk_q     <= o_blk_d;
    o_turn_q    <= o_turn_d;
    o_run_id_q  <= o_run_id_d;
    o_exit_q    <= o_exit_d;
    o_rcnt_q    <= o_rcnt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign tick_index_o     = o_tick_q;
  assign running_valid_o  = (o_run_id_q != '0);
  assign running_id_o     = o_run_id_q;
  assign ready_count_o    = o_rcnt_q;
  assign exit_valid_o     = (o_exit_q != '0);
  assign exit_id_o        = o_exit_q;
  assign departure_tick_o = (o_exit_q != '0) ? o_tick_q : '0;
  assign ready_total_o    = o_rdy_q;
  assign run_total_o      = o_run_q;
  assign blocked_total_o  = o_blk_q;
  assign turnaround_o     = o_turn_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rlen_q <= LIST_FULL) && (nlen_q <= LIST_FULL) && (blen_q <= LIST_FULL))
    else $error("list length beyond capacity");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output step");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLK_WR) |-> (k_q < blen_q) && (keep_q <= k_q))
    else $error("blocked walk out of range");
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && state_d == S_IDLE) |=> (out_valid_q && o_tick_q == $past(tick_q)))
    else $error("result tick does not match tick counter");
`endif

endmodule

`default_nettype wire
